FILE: sv/i2cs_pkg.sv
`default_nettype none

package i2cs_pkg;

    // field and register widths
    localparam int FIELD_W    = 10;
    localparam int DIM_W      = 11;
    localparam int KDIM_W     = 4;
    localparam int KOFF_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int ROW_W      = 30;
    localparam int COL_W      = 16;
    localparam int PATCH_W    = 22;
    localparam int AREA_W     = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // default limits
    localparam int MAX_KERNEL_DIM_DEF = 8;
    localparam int MAX_IMAGE_DIM_DEF  = 1024;
    localparam int MAX_CHANNELS_DEF   = 1024;
    localparam int MAX_BATCH_DEF      = 1024;

    typedef logic [FIELD_W-1:0]    field_t;
    typedef logic [DIM_W-1:0]      dim_t;
    typedef logic [KDIM_W-1:0]     kdim_t;
    typedef logic [KOFF_W-1:0]     koff_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [ROW_W-1:0]      row_t;
    typedef logic [COL_W-1:0]      col_t;
    typedef logic [PATCH_W-1:0]    patch_t;
    typedef logic [AREA_W-1:0]     area_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHANNELS    = 3'd0,
        CFG_IMAGE_ROWS  = 3'd1,
        CFG_IMAGE_COLS  = 3'd2,
        CFG_KERNEL_ROWS = 3'd3,
        CFG_KERNEL_COLS = 3'd4,
        CFG_STEP_SIZE   = 3'd5
    } cfg_reg_t;

    // effective configuration and derived geometry
    typedef struct packed {
        dim_t   channels;
        dim_t   image_rows;
        dim_t   image_cols;
        kdim_t  kernel_rows;
        kdim_t  kernel_cols;
        kdim_t  step;
        dim_t   out_cols;
        patch_t patches;
        area_t  area;
        area_t  step_kc;
    } cfg_t;

    // one pixel ready for expansion into its im2col positions
    typedef struct packed {
        row_t   row_base;
        col_t   col_base;
        dim_t   pr_hi;
        dim_t   pr_lo;
        dim_t   pc_hi;
        dim_t   pc_lo;
        koff_t  b_first;
        value_t value;
    } item_t;

    // ceil(2^16 / d), exact quotient for 11-bit dividends and d up to 15
    function automatic logic [16:0] recip(input kdim_t d);
        logic [16:0] m;
        case (d)
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            4'd9:    m = 17'd7282;
            4'd10:   m = 17'd6554;
            4'd11:   m = 17'd5958;
            4'd12:   m = 17'd5462;
            4'd13:   m = 17'd5042;
            4'd14:   m = 17'd4682;
            4'd15:   m = 17'd4370;
            default: m = 17'd65536;
        endcase
        return m;
    endfunction

    // x / d by reciprocal multiply
    function automatic dim_t div_step(input dim_t x, input kdim_t d);
        logic [27:0] p;
        p = 28'(x) * 28'(recip(d));
        return p[26:16];
    endfunction

endpackage

`default_nettype wire

FILE: sv/i2cs_cfg.sv
`default_nettype none

module i2cs_cfg #(
    parameter int MAX_KERNEL_DIM = i2cs_pkg::MAX_KERNEL_DIM_DEF,
    parameter int MAX_IMAGE_DIM  = i2cs_pkg::MAX_IMAGE_DIM_DEF,
    parameter int MAX_CHANNELS   = i2cs_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire i2cs_pkg::cfg_idx_t   cfg_index,
    input  wire i2cs_pkg::cfg_data_t  cfg_data,
    output i2cs_pkg::cfg_t            cfg
);

    i2cs_pkg::dim_t   channels_reg;
    i2cs_pkg::dim_t   image_rows_reg;
    i2cs_pkg::dim_t   image_cols_reg;
    i2cs_pkg::kdim_t  kernel_rows_reg;
    i2cs_pkg::kdim_t  kernel_cols_reg;
    i2cs_pkg::kdim_t  step_reg;

    i2cs_pkg::dim_t   eff_ch;
    i2cs_pkg::dim_t   eff_ir;
    i2cs_pkg::dim_t   eff_ic;
    i2cs_pkg::kdim_t  eff_kr;
    i2cs_pkg::kdim_t  eff_kc;
    i2cs_pkg::kdim_t  eff_st;

    i2cs_pkg::dim_t   out_rows_next;
    i2cs_pkg::dim_t   out_cols_next;
    i2cs_pkg::dim_t   out_rows_reg;
    i2cs_pkg::dim_t   out_cols_reg;
    i2cs_pkg::patch_t patches_reg;
    i2cs_pkg::area_t  area_reg;
    i2cs_pkg::area_t  step_kc_reg;

    function automatic i2cs_pkg::dim_t clamp_dim(input i2cs_pkg::dim_t v, input int hi);
        i2cs_pkg::dim_t r;
        if (v == '0)
        begin
            r = i2cs_pkg::dim_t'(1);
        end
        else if (int'(v) > hi)
        begin
            r = i2cs_pkg::dim_t'(hi);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    function automatic i2cs_pkg::kdim_t clamp_kdim(input i2cs_pkg::kdim_t v, input int hi);
        i2cs_pkg::kdim_t r;
        if (v == '0)
        begin
            r = i2cs_pkg::kdim_t'(1);
        end
        else if (int'(v) > hi)
        begin
            r = i2cs_pkg::kdim_t'(hi);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channels_reg    <= i2cs_pkg::dim_t'(1);
            image_rows_reg  <= i2cs_pkg::dim_t'(32);
            image_cols_reg  <= i2cs_pkg::dim_t'(32);
            kernel_rows_reg <= i2cs_pkg::kdim_t'(3);
            kernel_cols_reg <= i2cs_pkg::kdim_t'(3);
            step_reg        <= i2cs_pkg::kdim_t'(1);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                i2cs_pkg::CFG_CHANNELS:    channels_reg    <= cfg_data;
                i2cs_pkg::CFG_IMAGE_ROWS:  image_rows_reg  <= cfg_data;
                i2cs_pkg::CFG_IMAGE_COLS:  image_cols_reg  <= cfg_data;
                i2cs_pkg::CFG_KERNEL_ROWS: kernel_rows_reg <= cfg_data[3:0];
                i2cs_pkg::CFG_KERNEL_COLS: kernel_cols_reg <= cfg_data[3:0];
                i2cs_pkg::CFG_STEP_SIZE:   step_reg        <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective values
    always_comb
    begin
        eff_ch = clamp_dim(channels_reg, MAX_CHANNELS);
        eff_ir = clamp_dim(image_rows_reg, MAX_IMAGE_DIM);
        eff_ic = clamp_dim(image_cols_reg, MAX_IMAGE_DIM);
        eff_kr = clamp_kdim(kernel_rows_reg, MAX_KERNEL_DIM);
        eff_kc = clamp_kdim(kernel_cols_reg, MAX_KERNEL_DIM);
        eff_st = (step_reg == '0) ? i2cs_pkg::kdim_t'(1) : step_reg;
    end

    // output grid size, only meaningful while the kernel fits
    always_comb
    begin
        out_rows_next = i2cs_pkg::div_step(eff_ir - i2cs_pkg::dim_t'(eff_kr), eff_st)
                        + i2cs_pkg::dim_t'(1);
        out_cols_next = i2cs_pkg::div_step(eff_ic - i2cs_pkg::dim_t'(eff_kc), eff_st)
                        + i2cs_pkg::dim_t'(1);
    end

    // derived geometry, registered; patches is formed from the registered grid size
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_rows_reg <= i2cs_pkg::dim_t'(30);
            out_cols_reg <= i2cs_pkg::dim_t'(30);
            area_reg     <= i2cs_pkg::area_t'(9);
            step_kc_reg  <= i2cs_pkg::area_t'(3);
            patches_reg  <= i2cs_pkg::patch_t'(900);
        end
        else
        begin
            out_rows_reg <= out_rows_next;
            out_cols_reg <= out_cols_next;
            area_reg     <= i2cs_pkg::area_t'(eff_kr) * i2cs_pkg::area_t'(eff_kc);
            step_kc_reg  <= i2cs_pkg::area_t'(eff_st) * i2cs_pkg::area_t'(eff_kc);
            patches_reg  <= i2cs_pkg::patch_t'(out_rows_reg) * i2cs_pkg::patch_t'(out_cols_reg);
        end
    end

    always_comb
    begin
        cfg.channels    = eff_ch;
        cfg.image_rows  = eff_ir;
        cfg.image_cols  = eff_ic;
        cfg.kernel_rows = eff_kr;
        cfg.kernel_cols = eff_kc;
        cfg.step        = eff_st;
        cfg.out_cols    = out_cols_reg;
        cfg.patches     = patches_reg;
        cfg.area        = area_reg;
        cfg.step_kc     = step_kc_reg;
    end

endmodule

`default_nettype wire

FILE: sv/i2cs_front.sv
`default_nettype none

module i2cs_front #(
    parameter int MAX_BATCH = i2cs_pkg::MAX_BATCH_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire i2cs_pkg::cfg_t     cfg,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire i2cs_pkg::field_t   batch_index,
    input  wire i2cs_pkg::field_t   channel_index,
    input  wire i2cs_pkg::field_t   pixel_row,
    input  wire i2cs_pkg::field_t   pixel_col,
    input  wire i2cs_pkg::value_t   pixel_value,
    output logic                    item_valid,
    input  wire logic               item_take,
    output i2cs_pkg::item_t         item
);

    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic s4_load;

    // stage 1: captured request
    logic               s1_valid_reg;
    i2cs_pkg::field_t   s1_batch_reg;
    i2cs_pkg::field_t   s1_chan_reg;
    i2cs_pkg::field_t   s1_prow_reg;
    i2cs_pkg::field_t   s1_pcol_reg;
    i2cs_pkg::value_t   s1_value_reg;

    // stage 2: patch index bounds
    logic               s2_valid_reg;
    logic               s2_ok_reg;
    i2cs_pkg::field_t   s2_batch_reg;
    i2cs_pkg::field_t   s2_chan_reg;
    i2cs_pkg::field_t   s2_prow_reg;
    i2cs_pkg::field_t   s2_pcol_reg;
    i2cs_pkg::dim_t     s2_pr_hi_reg;
    i2cs_pkg::dim_t     s2_pr_lo_reg;
    i2cs_pkg::dim_t     s2_pc_hi_reg;
    i2cs_pkg::dim_t     s2_pc_lo_reg;
    i2cs_pkg::value_t   s2_value_reg;

    // stage 3: partial addresses
    logic               s3_valid_reg;
    logic               s3_hit_reg;
    i2cs_pkg::row_t     s3_bp_reg;
    i2cs_pkg::patch_t   s3_row_off_reg;
    i2cs_pkg::col_t     s3_cb_reg;
    i2cs_pkg::koff_t    s3_a_first_reg;
    i2cs_pkg::koff_t    s3_b_first_reg;
    i2cs_pkg::dim_t     s3_pr_hi_reg;
    i2cs_pkg::dim_t     s3_pr_lo_reg;
    i2cs_pkg::dim_t     s3_pc_hi_reg;
    i2cs_pkg::dim_t     s3_pc_lo_reg;
    i2cs_pkg::value_t   s3_value_reg;

    // stage 4: item for the expander
    logic               s4_valid_reg;
    i2cs_pkg::item_t    s4_item_reg;

    // stage 1 to 2 logic
    logic               fits;
    logic               ok;
    i2cs_pkg::dim_t     max_orow;
    i2cs_pkg::dim_t     max_ocol;
    i2cs_pkg::kdim_t    kr_m1;
    i2cs_pkg::kdim_t    kc_m1;
    i2cs_pkg::dim_t     orow_hi;
    i2cs_pkg::dim_t     ocol_hi;
    i2cs_pkg::dim_t     orow_lo;
    i2cs_pkg::dim_t     ocol_lo;
    i2cs_pkg::dim_t     st_m1;

    // stage 2 to 3 logic
    logic [14:0]        pr_st;
    logic [14:0]        pc_st;
    logic [14:0]        a_diff;
    logic [14:0]        b_diff;
    logic [31:0]        bp_full;
    logic [16:0]        cb_full;

    // stage 3 to 4 logic
    i2cs_pkg::area_t    a_kc;

    // load enables, back to front
    assign s4_load  = !s4_valid_reg || item_take;
    assign s3_load  = !s3_valid_reg || s4_load;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_stall = !s1_load;

    // stage 1
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_batch_reg <= batch_index;
            s1_chan_reg  <= channel_index;
            s1_prow_reg  <= pixel_row;
            s1_pcol_reg  <= pixel_col;
            s1_value_reg <= pixel_value;
        end
    end

    // range checks and bounds of the covering patch origins
    always_comb
    begin
        fits = (i2cs_pkg::dim_t'(cfg.kernel_rows) <= cfg.image_rows)
            && (i2cs_pkg::dim_t'(cfg.kernel_cols) <= cfg.image_cols);
        ok   = fits
            && (i2cs_pkg::dim_t'(s1_prow_reg) < cfg.image_rows)
            && (i2cs_pkg::dim_t'(s1_pcol_reg) < cfg.image_cols)
            && (i2cs_pkg::dim_t'(s1_chan_reg) < cfg.channels)
            && (int'(s1_batch_reg) < MAX_BATCH);
        max_orow = cfg.image_rows - i2cs_pkg::dim_t'(cfg.kernel_rows);
        max_ocol = cfg.image_cols - i2cs_pkg::dim_t'(cfg.kernel_cols);
        orow_hi  = (i2cs_pkg::dim_t'(s1_prow_reg) < max_orow) ?
                   i2cs_pkg::dim_t'(s1_prow_reg) : max_orow;
        ocol_hi  = (i2cs_pkg::dim_t'(s1_pcol_reg) < max_ocol) ?
                   i2cs_pkg::dim_t'(s1_pcol_reg) : max_ocol;
        kr_m1    = cfg.kernel_rows - i2cs_pkg::kdim_t'(1);
        kc_m1    = cfg.kernel_cols - i2cs_pkg::kdim_t'(1);
        orow_lo  = (s1_prow_reg >= i2cs_pkg::field_t'(kr_m1)) ?
                   i2cs_pkg::dim_t'(s1_prow_reg - i2cs_pkg::field_t'(kr_m1)) : '0;
        ocol_lo  = (s1_pcol_reg >= i2cs_pkg::field_t'(kc_m1)) ?
                   i2cs_pkg::dim_t'(s1_pcol_reg - i2cs_pkg::field_t'(kc_m1)) : '0;
        st_m1    = i2cs_pkg::dim_t'(cfg.step) - i2cs_pkg::dim_t'(1);
    end

    // stage 2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_load)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load)
        begin
            s2_ok_reg    <= ok;
            s2_batch_reg <= s1_batch_reg;
            s2_chan_reg  <= s1_chan_reg;
            s2_prow_reg  <= s1_prow_reg;
            s2_pcol_reg  <= s1_pcol_reg;
            s2_pr_hi_reg <= i2cs_pkg::div_step(orow_hi, cfg.step);
            s2_pr_lo_reg <= i2cs_pkg::div_step(orow_lo + st_m1, cfg.step);
            s2_pc_hi_reg <= i2cs_pkg::div_step(ocol_hi, cfg.step);
            s2_pc_lo_reg <= i2cs_pkg::div_step(ocol_lo + st_m1, cfg.step);
            s2_value_reg <= s1_value_reg;
        end
    end

    // first kernel offsets and address products
    always_comb
    begin
        pr_st   = 15'(s2_pr_hi_reg) * 15'(cfg.step);
        pc_st   = 15'(s2_pc_hi_reg) * 15'(cfg.step);
        a_diff  = 15'(s2_prow_reg) - pr_st;
        b_diff  = 15'(s2_pcol_reg) - pc_st;
        bp_full = 32'(s2_batch_reg) * 32'(cfg.patches);
        cb_full = 17'(s2_chan_reg) * 17'(cfg.area);
    end

    // stage 3
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_load)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load)
        begin
            s3_hit_reg     <= s2_ok_reg && (s2_pr_hi_reg >= s2_pr_lo_reg)
                                        && (s2_pc_hi_reg >= s2_pc_lo_reg);
            s3_bp_reg      <= bp_full[i2cs_pkg::ROW_W-1:0];
            s3_row_off_reg <= i2cs_pkg::patch_t'(s2_pr_hi_reg) * i2cs_pkg::patch_t'(cfg.out_cols);
            s3_cb_reg      <= cb_full[i2cs_pkg::COL_W-1:0];
            s3_a_first_reg <= a_diff[i2cs_pkg::KOFF_W-1:0];
            s3_b_first_reg <= b_diff[i2cs_pkg::KOFF_W-1:0];
            s3_pr_hi_reg   <= s2_pr_hi_reg;
            s3_pr_lo_reg   <= s2_pr_lo_reg;
            s3_pc_hi_reg   <= s2_pc_hi_reg;
            s3_pc_lo_reg   <= s2_pc_lo_reg;
            s3_value_reg   <= s2_value_reg;
        end
    end

    assign a_kc = i2cs_pkg::area_t'(s3_a_first_reg) * i2cs_pkg::area_t'(cfg.kernel_cols);

    // stage 4, pixels without any result are dropped here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg <= 1'b0;
        end
        else if (s4_load)
        begin
            s4_valid_reg <= s3_valid_reg && s3_hit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_load)
        begin
            s4_item_reg.row_base <= s3_bp_reg + i2cs_pkg::row_t'(s3_row_off_reg);
            s4_item_reg.col_base <= s3_cb_reg + i2cs_pkg::col_t'(a_kc);
            s4_item_reg.pr_hi    <= s3_pr_hi_reg;
            s4_item_reg.pr_lo    <= s3_pr_lo_reg;
            s4_item_reg.pc_hi    <= s3_pc_hi_reg;
            s4_item_reg.pc_lo    <= s3_pc_lo_reg;
            s4_item_reg.b_first  <= s3_b_first_reg;
            s4_item_reg.value    <= s3_value_reg;
        end
    end

    assign item_valid = s4_valid_reg;
    assign item       = s4_item_reg;

`ifndef SYNTHESIS
    // every item handed on has at least one result
    a_item_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        s4_valid_reg |-> (s4_item_reg.pr_hi >= s4_item_reg.pr_lo)
                      && (s4_item_reg.pc_hi >= s4_item_reg.pc_lo))
        else $error("empty item reached the expander");
`endif

endmodule

`default_nettype wire

FILE: sv/i2cs_expand.sv
`default_nettype none

module i2cs_expand (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire i2cs_pkg::cfg_t     cfg,
    input  wire logic               item_valid,
    output logic                    item_take,
    input  wire i2cs_pkg::item_t    item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output i2cs_pkg::row_t          dest_row,
    output i2cs_pkg::col_t          dest_col,
    output i2cs_pkg::value_t        dest_value,
    output logic                    last
);

    // walk state
    logic               busy_reg;
    logic               busy_next;
    i2cs_pkg::row_t     row_ptr_reg;
    i2cs_pkg::row_t     row_ptr_next;
    i2cs_pkg::col_t     col_ptr_reg;
    i2cs_pkg::col_t     col_ptr_next;
    i2cs_pkg::dim_t     pr_reg;
    i2cs_pkg::dim_t     pr_next;
    i2cs_pkg::dim_t     pr_lo_reg;
    i2cs_pkg::dim_t     pr_lo_next;
    i2cs_pkg::dim_t     pc_reg;
    i2cs_pkg::dim_t     pc_next;
    i2cs_pkg::dim_t     pc_hi_reg;
    i2cs_pkg::dim_t     pc_hi_next;
    i2cs_pkg::dim_t     pc_lo_reg;
    i2cs_pkg::dim_t     pc_lo_next;
    i2cs_pkg::koff_t    b_reg;
    i2cs_pkg::koff_t    b_next;
    i2cs_pkg::koff_t    b_first_reg;
    i2cs_pkg::koff_t    b_first_next;
    i2cs_pkg::value_t   value_reg;
    i2cs_pkg::value_t   value_next;

    // output register
    logic               out_valid_reg;
    i2cs_pkg::row_t     dest_row_reg;
    i2cs_pkg::col_t     dest_col_reg;
    i2cs_pkg::value_t   dest_value_reg;
    logic               last_reg;

    logic               out_load;
    logic               emit;
    logic               last_now;

    assign out_load  = !out_valid_reg || !out_stall;
    assign emit      = busy_reg && out_load;
    assign last_now  = (pc_reg == pc_lo_reg) && (pr_reg == pr_lo_reg);
    assign item_take = item_valid && (!busy_reg || (emit && last_now));

    // next walk position: columns inner, rows outer, both descending
    always_comb
    begin
        busy_next    = busy_reg;
        row_ptr_next = row_ptr_reg;
        col_ptr_next = col_ptr_reg;
        pr_next      = pr_reg;
        pr_lo_next   = pr_lo_reg;
        pc_next      = pc_reg;
        pc_hi_next   = pc_hi_reg;
        pc_lo_next   = pc_lo_reg;
        b_next       = b_reg;
        b_first_next = b_first_reg;
        value_next   = value_reg;
        if (item_take)
        begin
            busy_next    = 1'b1;
            row_ptr_next = item.row_base;
            col_ptr_next = item.col_base;
            pr_next      = item.pr_hi;
            pr_lo_next   = item.pr_lo;
            pc_next      = item.pc_hi;
            pc_hi_next   = item.pc_hi;
            pc_lo_next   = item.pc_lo;
            b_next       = item.b_first;
            b_first_next = item.b_first;
            value_next   = item.value;
        end
        else if (emit)
        begin
            if (pc_reg != pc_lo_reg)
            begin
                pc_next = pc_reg - i2cs_pkg::dim_t'(1);
                b_next  = b_reg + i2cs_pkg::koff_t'(cfg.step);
            end
            else if (pr_reg != pr_lo_reg)
            begin
                pr_next      = pr_reg - i2cs_pkg::dim_t'(1);
                pc_next      = pc_hi_reg;
                b_next       = b_first_reg;
                row_ptr_next = row_ptr_reg - i2cs_pkg::row_t'(cfg.out_cols);
                col_ptr_next = col_ptr_reg + i2cs_pkg::col_t'(cfg.step_kc);
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        row_ptr_reg <= row_ptr_next;
        col_ptr_reg <= col_ptr_next;
        pr_reg      <= pr_next;
        pr_lo_reg   <= pr_lo_next;
        pc_reg      <= pc_next;
        pc_hi_reg   <= pc_hi_next;
        pc_lo_reg   <= pc_lo_next;
        b_reg       <= b_next;
        b_first_reg <= b_first_next;
        value_reg   <= value_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            dest_row_reg   <= row_ptr_reg + i2cs_pkg::row_t'(pc_reg);
            dest_col_reg   <= col_ptr_reg + i2cs_pkg::col_t'(b_reg);
            dest_value_reg <= value_reg;
            last_reg       <= last_now;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dest_row   = dest_row_reg;
    assign dest_col   = dest_col_reg;
    assign dest_value = dest_value_reg;
    assign last       = last_reg;

`ifndef SYNTHESIS
    // walk never passes its lower bounds nor its upper column bound
    a_walk_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (pc_reg >= pc_lo_reg) && (pr_reg >= pr_lo_reg)
                  && (pc_hi_reg >= pc_reg))
        else $error("patch walk out of bounds");

    // column offset stays inside the kernel
    a_koff_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (i2cs_pkg::kdim_t'(b_reg) < cfg.kernel_cols))
        else $error("kernel column offset out of range");

    // a result that is not the last keeps the walk going
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        emit && !last_now |=> busy_reg && out_valid_reg)
        else $error("walk ended before the last result");
`endif

endmodule

`default_nettype wire

FILE: sv/im2col_scatter_address_gen.sv
`default_nettype none

// im2col scatter address generator
// input channel: one image element per request (batch, channel, row, column, value),
//   taken at a rising edge with in_valid high and in_stall low
// output channel: one im2col position per request (dest_row, dest_col, dest_value),
//   taken with out_valid high and out_stall low; last marks the final position
//   of an element, elements covered by no patch give nothing
// configuration: cfg_wr_en writes cfg_data to register cfg_index; write only
//   while no element is in flight
// path: an element taken into stage 1 passes stages 2 to 4 and the walk registers
//   before its first position is in the output register when the output is free
// throughput: one position per cycle while out_stall is low; an element with n
//   positions holds the walk until its last (9 for a 3x3 kernel at step 1 inside
//   the image); a four-stage front end feeds it, one element per cycle unless stalled
// reset: rst_n clears all valid bits and loads the default geometry
//   (1 channel, 32x32 image, 3x3 kernel, step 1)
// stall: out_stall freezes the output register and the walk; the front end
//   fills up and then raises in_stall, nothing is lost or repeated
module im2col_scatter_address_gen #(
    parameter int MAX_KERNEL_DIM = i2cs_pkg::MAX_KERNEL_DIM_DEF,
    parameter int MAX_IMAGE_DIM  = i2cs_pkg::MAX_IMAGE_DIM_DEF,
    parameter int MAX_CHANNELS   = i2cs_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_BATCH      = i2cs_pkg::MAX_BATCH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire i2cs_pkg::cfg_idx_t   cfg_index,
    input  wire i2cs_pkg::cfg_data_t  cfg_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire i2cs_pkg::field_t     batch_index,
    input  wire i2cs_pkg::field_t     channel_index,
    input  wire i2cs_pkg::field_t     pixel_row,
    input  wire i2cs_pkg::field_t     pixel_col,
    input  wire i2cs_pkg::value_t     pixel_value,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output i2cs_pkg::row_t            dest_row,
    output i2cs_pkg::col_t            dest_col,
    output i2cs_pkg::value_t          dest_value,
    output logic                      last
);

    i2cs_pkg::cfg_t  cfg;
    logic            item_valid;
    logic            item_take;
    i2cs_pkg::item_t item;

    // configuration registers and derived geometry
    i2cs_cfg #(
        .MAX_KERNEL_DIM (MAX_KERNEL_DIM),
        .MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
        .MAX_CHANNELS   (MAX_CHANNELS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // per element address precompute
    i2cs_front #(
        .MAX_BATCH (MAX_BATCH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .batch_index   (batch_index),
        .channel_index (channel_index),
        .pixel_row     (pixel_row),
        .pixel_col     (pixel_col),
        .pixel_value   (pixel_value),
        .item_valid    (item_valid),
        .item_take     (item_take),
        .item          (item)
    );

    // walk over covering patches, one position per cycle while out_stall is low
    i2cs_expand u_expand (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .dest_row   (dest_row),
        .dest_col   (dest_col),
        .dest_value (dest_value),
        .last       (last)
    );

endmodule

`default_nettype wire
